// ===== hdl/scc_pkg.sv =====
// shared constants, types and helpers for the stamp cover check block
// no dependencies
package scc_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = $clog2(CELL_DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int SUM_W      = $clog2(CELL_DEPTH + 1);
  localparam int DIM_W      = 7;
  localparam int CRD_W      = DIM_W + 1;
  localparam int IDX_W      = 3;

  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [IDX_W-1:0] {
    REG_STAMP_H = 3'd0,
    REG_STAMP_W = 3'd1,
    REG_GRID_R  = 3'd2,
    REG_GRID_C  = 3'd3
  } cfg_reg_t;

  function automatic dim_t clamp_dim(dim_t v, dim_t maxv);
    dim_t res;
    if (v == '0) begin
      res = dim_t'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== hdl/scc_if.sv =====
// handshake channels of the stamp cover check block: cells, verdict, config
// depends on scc_pkg
interface scc_cell_if;
  logic valid;
  logic ready;
  logic occupied;
  modport source (output valid, output occupied, input ready);
  modport sink (input valid, input occupied, output ready);
endinterface

interface scc_verdict_if;
  logic valid;
  logic ready;
  logic possible;
  modport source (output valid, output possible, input ready);
  modport sink (input valid, input possible, output ready);
endinterface

interface scc_cfg_if import scc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DIM_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/stamp_cover_check_top.sv =====
// stamp cover check top level: grid load, prefix sum passes, verdict register
// depends on scc_pkg, scc_if, scc_ram
//
// Cells are taken one per beat, in row-major order, while the block is loading.
// The beat that completes the grid starts three passes over the stored cells:
// an occupancy prefix build, a free-window mark and window prefix build, and
// a cover check. The single read port of each sum memory sets the pace of
// these passes, since every rectangle sum needs four corner reads. When a job
// ends, its verdict waits in its output register while the next grid loads.
module stamp_cover_check_top import scc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  scc_cfg_if.sink       cfg,
  scc_cell_if.sink      cells,
  scc_verdict_if.source verdict
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_BUILD,
    S_MARK,
    S_CHECK,
    S_DONE
  } phase_t;

  localparam int PROD_W = 2 * CRD_W;

  phase_t             phase;
  dim_t               stamp_h, stamp_w, grid_r, grid_c;
  dim_t               rows_j, cols_j, sh, sw;
  logic               win_ok;
  logic [CNT_W-1:0]   load_count;
  dim_t               r, c;
  logic [ADDR_W-1:0]  lin;
  logic [2:0]         k;
  logic [SUM_W-1:0]   rowsum, acc;
  logic               zf, neg, fits_q, up_zero;
  logic               ok;
  logic               out_valid, out_poss;

  dim_t               rows_now, cols_now;
  logic [CNT_W-1:0]   total, count_next;
  logic               in_acc, job_end;

  logic               cell_we, cell_re, cell_rdata;
  logic [ADDR_W-1:0]  cell_raddr;
  logic               p_we, p_re, q_we, q_re;
  logic [ADDR_W-1:0]  p_raddr, q_raddr, up_addr, crn_addr;
  logic [SUM_W-1:0]   p_wdata, q_wdata, p_rdata, q_rdata;

  logic [CRD_W-1:0]   ra, rb, ca, cb, crn_r, crn_c, r1, c1, sh_x, sw_x;
  logic               fits, crn_zero, crn_neg;
  logic [PROD_W-1:0]  mul_a, mul_b, crn_full;
  logic [SUM_W-1:0]   src, term, acc_sum, row_base, up_val;
  logic               last_col, last_row, w_bit;

  assign rows_now   = clamp_dim(grid_r, dim_t'(MAX_ROWS));
  assign cols_now   = clamp_dim(grid_c, dim_t'(MAX_COLS));
  assign total      = CNT_W'(rows_now) * CNT_W'(cols_now);
  assign count_next = load_count + CNT_W'(1);

  assign cells.ready   = (phase == S_LOAD);
  assign cfg.ready     = 1'b1;
  assign verdict.valid    = out_valid;
  assign verdict.possible = out_poss;

  assign in_acc  = cells.valid && cells.ready;
  assign job_end = in_acc && (count_next >= total);

  // corner selection for the rectangle sums
  assign r1   = CRD_W'(r) + CRD_W'(1);
  assign c1   = CRD_W'(c) + CRD_W'(1);
  assign sh_x = CRD_W'(sh);
  assign sw_x = CRD_W'(sw);

  always_comb begin
    if (phase == S_MARK) begin
      ra = CRD_W'(r);
      ca = CRD_W'(c);
      rb = CRD_W'(r) + sh_x;
      cb = CRD_W'(c) + sw_x;
    end else begin
      rb = r1;
      cb = c1;
      ra = (r1 > sh_x) ? r1 - sh_x : '0;
      ca = (c1 > sw_x) ? c1 - sw_x : '0;
    end
    fits = win_ok && (rb <= CRD_W'(rows_j)) && (cb <= CRD_W'(cols_j));
    case (k[1:0])
      2'd0: begin
        crn_r = rb; crn_c = cb; crn_neg = 1'b0;
      end
      2'd1: begin
        crn_r = ra; crn_c = cb; crn_neg = 1'b1;
      end
      2'd2: begin
        crn_r = rb; crn_c = ca; crn_neg = 1'b1;
      end
      default: begin
        crn_r = ra; crn_c = ca; crn_neg = 1'b0;
      end
    endcase
    crn_zero = (crn_r == '0) || (crn_c == '0) || ((phase == S_MARK) && !fits);
  end

  assign mul_a    = PROD_W'(crn_r - CRD_W'(1));
  assign mul_b    = PROD_W'(cols_j);
  assign crn_full = mul_a * mul_b + PROD_W'(crn_c - CRD_W'(1));
  assign crn_addr = crn_full[ADDR_W-1:0];
  assign up_addr  = lin - ADDR_W'(cols_j);

  assign last_col = (c == cols_j - dim_t'(1));
  assign last_row = (r == rows_j - dim_t'(1));

  // accumulation of corner reads
  assign src     = (phase == S_MARK) ? p_rdata : q_rdata;
  assign term    = zf ? '0 : src;
  assign acc_sum = neg ? acc - term : acc + term;
  assign w_bit   = fits_q && (acc_sum == '0);
  assign row_base = (c == '0) ? '0 : rowsum;

  always_comb begin
    if (phase == S_MARK) begin
      up_val = up_zero ? '0 : q_rdata;
    end else begin
      up_val = up_zero ? '0 : p_rdata;
    end
  end

  // memory ports
  assign cell_we    = in_acc && (load_count < CNT_W'(CELL_DEPTH));
  assign cell_re    = ((phase == S_BUILD) || (phase == S_CHECK)) && (k == 3'd0);
  assign cell_raddr = lin;

  assign p_we    = (phase == S_BUILD) && (k == 3'd1);
  assign p_wdata = up_val + row_base + SUM_W'(cell_rdata);
  assign p_re    = ((phase == S_BUILD) && (k == 3'd0)) || ((phase == S_MARK) && (k < 3'd4));
  assign p_raddr = (phase == S_BUILD) ? up_addr : crn_addr;

  assign q_we    = (phase == S_MARK) && (k == 3'd4);
  assign q_wdata = up_val + row_base + SUM_W'(w_bit);
  assign q_re    = ((phase == S_MARK) && (k == 3'd0)) || ((phase == S_CHECK) && (k < 3'd4));
  assign q_raddr = (phase == S_MARK) ? up_addr : crn_addr;

  scc_ram #(.DEPTH(CELL_DEPTH), .WIDTH(1)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (cells.occupied),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  scc_ram #(.DEPTH(CELL_DEPTH), .WIDTH(SUM_W)) u_occ_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (lin),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  scc_ram #(.DEPTH(CELL_DEPTH), .WIDTH(SUM_W)) u_cover_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (lin),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= S_LOAD;
      stamp_h    <= dim_t'(1);
      stamp_w    <= dim_t'(1);
      grid_r     <= dim_t'(64);
      grid_c     <= dim_t'(64);
      load_count <= '0;
      out_valid  <= 1'b0;
      out_poss   <= 1'b0;
      k          <= '0;
      r          <= '0;
      c          <= '0;
      lin        <= '0;
      acc        <= '0;
      ok         <= 1'b1;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_STAMP_H: stamp_h <= cfg.data;
          REG_STAMP_W: stamp_w <= cfg.data;
          REG_GRID_R:  grid_r  <= cfg.data;
          REG_GRID_C:  grid_c  <= cfg.data;
          default: ;
        endcase
      end
      if (verdict.valid && verdict.ready && phase != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (phase)
        S_LOAD: begin
          if (in_acc) begin
            if (job_end) begin
              load_count <= '0;
              phase      <= S_BUILD;
              rows_j     <= rows_now;
              cols_j     <= cols_now;
              sh         <= stamp_h;
              sw         <= stamp_w;
              win_ok     <= (stamp_h != '0) && (stamp_w != '0) &&
                            (stamp_h <= rows_now) && (stamp_w <= cols_now);
              r          <= '0;
              c          <= '0;
              lin        <= '0;
              k          <= '0;
              acc        <= '0;
              ok         <= 1'b1;
            end else begin
              load_count <= count_next;
            end
          end
        end
        S_BUILD, S_MARK, S_CHECK: begin
          if (k == 3'd0) begin
            up_zero <= (r == '0);
          end
          if (phase != S_BUILD && k < 3'd4) begin
            zf  <= crn_zero;
            neg <= crn_neg;
          end
          if (phase == S_MARK && k == 3'd0) begin
            fits_q <= fits;
          end
          if (phase != S_BUILD && k != 3'd0 && k != 3'd4) begin
            acc <= acc_sum;
          end
          if ((phase == S_BUILD && k == 3'd1) || (phase != S_BUILD && k == 3'd4)) begin
            k   <= '0;
            acc <= '0;
            if (phase == S_BUILD) begin
              rowsum <= row_base + SUM_W'(cell_rdata);
            end else if (phase == S_MARK) begin
              rowsum <= row_base + SUM_W'(w_bit);
            end else if (!cell_rdata && acc_sum == '0) begin
              ok <= 1'b0;
            end
            if (last_col) begin
              c <= '0;
              if (last_row) begin
                r   <= '0;
                lin <= '0;
                case (phase)
                  S_BUILD: phase <= S_MARK;
                  S_MARK:  phase <= S_CHECK;
                  default: phase <= S_DONE;
                endcase
              end else begin
                r   <= r + dim_t'(1);
                lin <= lin + ADDR_W'(1);
              end
            end else begin
              c   <= c + dim_t'(1);
              lin <= lin + ADDR_W'(1);
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || verdict.ready) begin
            out_valid <= 1'b1;
            out_poss  <= ok;
            phase     <= S_LOAD;
          end
        end
        default: phase <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_job_starts: assert property (@(posedge clk) disable iff (rst)
    job_end |=> (phase == S_BUILD))
    else $error("last cell did not start the prefix build");

  a_verdict_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(phase) == S_DONE))
    else $error("verdict raised outside the done state");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    load_count < CNT_W'(CELL_DEPTH))
    else $error("load count beyond cell store");

  a_lin_tracks: assert property (@(posedge clk) disable iff (rst)
    (phase == S_BUILD || phase == S_MARK || phase == S_CHECK) |->
      (lin == ADDR_W'(int'(r) * int'(cols_j) + int'(c))))
    else $error("linear cell index out of step with row and column");
`endif

endmodule

// ===== hdl/scc_ram.sv =====
// simple dual port ram: one write port, one read port with registered data
// no dependencies
module scc_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench for stamp_cover_check_top: drives grids and config, predicts each verdict
// depends on scc_pkg, scc_if and the block under test in hdl
module tb_top;
  import scc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int FILL_FREE = 0;
  localparam int FILL_FULL = 1;
  localparam int FILL_RAND = 2;
  localparam int STALL_LIMIT = 200000;
  localparam int ITEM_GOAL = 1200;
  localparam int FINAL_CELLS = 256;

  typedef struct {
    int   sh, sw, gr, gc;
    int   fill;
    bit   typed;
    bit   verdict;
  } job_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  scc_cfg_if     cfg ();
  scc_cell_if    cells ();
  scc_verdict_if verdict ();

  stamp_cover_check_top DUT (
    .clk(clk), .rst(rst), .cfg(cfg), .cells(cells), .verdict(verdict)
  );

  // predictor state
  bit         grid_mem [CELL_DEPTH];
  int         load_idx;
  logic [6:0] stamp_h, stamp_w, rows_cfg, cols_cfg;

  bit verdict_q [$];
  int mismatches;
  int items_sent;
  int stall_cycles;
  bit quiet;
  bit bad;
  int src_burst;
  int snk_burst;

  function automatic int fit_dim(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic bit coverage_verdict(int rows, int cols);
    int occ [MAX_ROWS+1][MAX_COLS+1];
    int dif [MAX_ROWS][MAX_COLS];
    int cov [MAX_ROWS+1][MAX_COLS+1];
    int sh, sw, s;
    sh = int'(stamp_h);
    sw = int'(stamp_w);
    for (int r = 0; r <= rows; r++) begin
      for (int c = 0; c <= cols; c++) begin
        occ[r][c] = 0;
        cov[r][c] = 0;
        if (r < rows && c < cols) dif[r][c] = 0;
      end
    end
    for (int r = 1; r <= rows; r++) begin
      for (int c = 1; c <= cols; c++) begin
        occ[r][c] = occ[r-1][c] + occ[r][c-1] - occ[r-1][c-1]
                    + int'(grid_mem[(r-1)*cols + c-1]);
      end
    end
    if (sh != 0 && sw != 0 && sh <= rows && sw <= cols) begin
      for (int r = 0; r + sh <= rows; r++) begin
        for (int c = 0; c + sw <= cols; c++) begin
          s = occ[r+sh][c+sw] - occ[r][c+sw] - occ[r+sh][c] + occ[r][c];
          if (s == 0) begin
            dif[r][c] += 1;
            if (r + sh < rows) dif[r+sh][c] -= 1;
            if (c + sw < cols) dif[r][c+sw] -= 1;
            if (r + sh < rows && c + sw < cols) dif[r+sh][c+sw] += 1;
          end
        end
      end
    end
    for (int r = 1; r <= rows; r++) begin
      for (int c = 1; c <= cols; c++) begin
        cov[r][c] = cov[r-1][c] + cov[r][c-1] - cov[r-1][c-1] + dif[r-1][c-1];
        if (!grid_mem[(r-1)*cols + c-1] && cov[r][c] == 0) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic predict_cell(input bit occupied, output bit done, output bit res);
    int rows, cols;
    rows = fit_dim(rows_cfg, MAX_ROWS);
    cols = fit_dim(cols_cfg, MAX_COLS);
    if (load_idx < CELL_DEPTH) grid_mem[load_idx] = occupied;
    load_idx++;
    done = 1'b0;
    res = 1'b0;
    if (load_idx >= rows * cols) begin
      load_idx = 0;
      done = 1'b1;
      res = coverage_verdict(rows, cols);
    end
  endtask

  function automatic int next_burst();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 2) return $urandom_range(1, 17);
    return 0;
  endfunction

  // sink-side stalls
  always @(negedge clk) begin
    if (rst) begin
      verdict.ready <= 1'b0;
      snk_burst <= 0;
    end else if (snk_burst > 0) begin
      verdict.ready <= 1'b0;
      snk_burst <= snk_burst - 1;
    end else begin
      verdict.ready <= 1'b1;
      snk_burst <= ($urandom_range(0, 3) == 0) ? next_burst() : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && verdict.valid && verdict.ready) begin
      if (verdict_q.size() == 0) begin
        bad = 1'b1;
        if (mismatches < 10) $display("verdict beat with none expected: %0b", verdict.possible);
        mismatches++;
      end else begin
        if (verdict.possible !== verdict_q[0]) begin
          if (mismatches < 10)
            $display("possible: expected %0b, got %0b", verdict_q[0], verdict.possible);
          mismatches++;
          bad = 1'b1;
        end
        void'(verdict_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((cfg.valid && cfg.ready) || (cells.valid && cells.ready)
        || (verdict.valid && verdict.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("stamp_cover_check_top: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [6:0] val);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_STAMP_H: stamp_h = val;
      REG_STAMP_W: stamp_w = val;
      REG_GRID_R:  rows_cfg = val;
      REG_GRID_C:  cols_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_grid(input int sh, input int sw, input int gr, input int gc);
    write_reg(REG_STAMP_H, sh[6:0]);
    write_reg(REG_STAMP_W, sw[6:0]);
    write_reg(REG_GRID_R, gr[6:0]);
    write_reg(REG_GRID_C, gc[6:0]);
  endtask

  task automatic send_cell(input bit occupied, input bit typed, input bit typed_val);
    int gap;
    bit done, res;
    gap = (src_burst > 0) ? 0 : next_burst();
    if (gap > 0) begin
      cells.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cells.valid = 1'b1;
    cells.occupied = occupied;
    do @(posedge clk); while (!cells.ready);
    predict_cell(occupied, done, res);
    if (done) verdict_q.push_back(typed ? typed_val : res);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    cells.valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_job(input int fill, input int density, input bit typed, input bit tv);
    int n;
    bit v;
    n = fit_dim(rows_cfg, MAX_ROWS) * fit_dim(cols_cfg, MAX_COLS);
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_FREE: v = 1'b0;
        FILL_FULL: v = 1'b1;
        default:   v = ($urandom_range(0, 99) < density);
      endcase
      send_cell(v, typed, tv);
    end
  endtask

  job_row_t directed [] = '{
    '{1, 1, 1, 1, FILL_FREE, 1'b1, 1'b1},
    '{1, 1, 1, 1, FILL_FULL, 1'b1, 1'b1},
    '{3, 3, 2, 2, FILL_FREE, 1'b1, 1'b0},
    '{3, 3, 2, 2, FILL_FULL, 1'b1, 1'b1},
    '{0, 2, 2, 2, FILL_FREE, 1'b1, 1'b0},
    '{2, 0, 1, 2, FILL_FULL, 1'b1, 1'b1},
    '{1, 3, 0, 3, FILL_FREE, 1'b1, 1'b1},
    '{2, 2, 2, 3, FILL_RAND, 1'b0, 1'b0},
    '{2, 1, 3, 2, FILL_RAND, 1'b0, 1'b0}
  };

  initial begin
    int sh, sw, gr, gc, jobs, density;
    items_sent = 0;
    quiet = 1'b0;
    src_burst = 0;
    load_idx = 0;
    stamp_h = 7'd1;
    stamp_w = 7'd1;
    rows_cfg = 7'd64;
    cols_cfg = 7'd64;
    cfg.valid = 1'b0;
    cfg.index = REG_STAMP_H;
    cfg.data = '0;
    cells.valid = 1'b0;
    cells.occupied = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      set_grid(directed[i].sh, directed[i].sw, directed[i].gr, directed[i].gc);
      run_job(directed[i].fill, 50, directed[i].typed, directed[i].verdict);
      wait_idle();
    end

    // grid shrunk while a job is partly loaded
    set_grid(1, 1, 3, 3);
    for (int i = 0; i < 5; i++) send_cell(i[0], 1'b0, 1'b0);
    wait_idle();
    write_reg(REG_SPARE, 7'h7f);
    write_reg(REG_GRID_R, 7'd1);
    write_reg(REG_GRID_C, 7'd2);
    send_cell(1'b0, 1'b0, 1'b0);
    wait_idle();

    while (items_sent < ITEM_GOAL - FINAL_CELLS) begin
      if (items_sent > ITEM_GOAL / 2) quiet = 1'b1;
      gr = $urandom_range(1, 7);
      gc = $urandom_range(1, 7);
      case ($urandom_range(0, 9))
        0: gr = ($urandom_range(0, 1)) ? 0 : $urandom_range(64, 127);
        1: gc = ($urandom_range(0, 1)) ? 0 : $urandom_range(64, 127);
        default: ;
      endcase
      if (gr > 8) gc = $urandom_range(0, 1);
      if (gc > 8) gr = $urandom_range(0, 1);
      sh = $urandom_range(1, 3);
      sw = $urandom_range(1, 3);
      case ($urandom_range(0, 11))
        0: sh = 0;
        1: sw = $urandom_range(64, 127);
        2: sh = $urandom_range(4, 9);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE - IDX_W'($urandom_range(0, 2)), 7'($urandom));
      set_grid(sh, sw, gr, gc);
      jobs = $urandom_range(1, 3);
      for (int j = 0; j < jobs; j++) begin
        density = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(2, 40);
        run_job(FILL_RAND, density, 1'b0, 1'b0);
      end
      wait_idle();
    end

    // one grid of full height
    set_grid(2, 3, 64, FINAL_CELLS / 64);
    run_job(FILL_RAND, 1, 1'b0, 1'b0);
    wait_idle();
    repeat (100) @(negedge clk);

    if (!bad && mismatches == 0 && verdict_q.size() == 0) begin
      $display("stamp_cover_check_top: match");
    end else begin
      $display("stamp_cover_check_top: mismatch");
    end
    $finish;
  end

endmodule
